FILE: hw/rtl/fct_pkg.sv
package fct_pkg;

    // power of two: the home slot is the low bits of the hash
    localparam int TABLE_SIZE = 1024;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);

    localparam logic [2:0] FUNC_LOOKUP = 3'd0;
    localparam logic [2:0] FUNC_CREATE = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_TICK   = 3'd3;
    localparam logic [2:0] FUNC_REAP   = 3'd4;

    localparam logic [1:0] RSP_OK   = 2'd0;
    localparam logic [1:0] RSP_MISS = 2'd1;
    localparam logic [1:0] RSP_FULL = 2'd2;

    localparam logic [1:0] ENT_FREE   = 2'd0;
    localparam logic [1:0] ENT_ACTIVE = 2'd1;
    localparam logic [1:0] ENT_CLOSED = 2'd2;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [15:0] TIMEOUT_RST = 16'd300;

    typedef struct packed {
        logic [2:0]        func;
        logic [31:0]       source_address;
        logic [15:0]       source_port;
        logic [31:0]       dest_address;
        logic [15:0]       dest_port;
        logic [SLOT_W-1:0] target_slot;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  result_slot;
        logic [COUNT_W-1:0] reaped_count;
    } t_rsp;

endpackage

FILE: hw/rtl/flow_connection_table.sv
// Flow connection table: open-addressing hash table keyed by the flow tuple, FNV-1a home
// slot and linear probing. One request in, one response out. Lookup and create pass from
// the accept through hashing (one multiply per key byte, twelve key bytes), a step that
// takes the home slot from the low hash bits (TABLE_SIZE is a power of two), then probe
// one slot per cycle from the single read port of the entry memories, and then hand over
// the response. Tick and unused codes go straight from the accept to the response; remove
// first reads its target slot. Reap walks every slot, one a cycle. A response still
// waiting on the output holds the next request in the response step. After reset a
// clearing pass over every slot runs before the first request is taken; configuration
// writes take effect at once, so they belong between requests.
module flow_connection_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fct_pkg::t_req        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fct_pkg::t_rsp        o_out_data
);

    localparam int TABLE_SIZE = fct_pkg::TABLE_SIZE;
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [AW:0]   TS   = (AW+1)'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_PROBE = 4'd4;
    localparam logic [3:0] S_RMV   = 4'd5;
    localparam logic [3:0] S_REAP  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [1:0]   mem_st [TABLE_SIZE];
    logic [127:0] mem_dat [TABLE_SIZE];  // {seen_sec, dest_addr, port_pair, src_addr}

    logic [3:0]          r_state, n_state;
    logic [AW-1:0]       r_slot, n_slot;
    logic [AW:0]         r_pc, n_pc;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [31:0]         r_sec, n_sec;
    logic [15:0]         r_timeout;
    logic [31:0]         r_h, n_h;
    logic [3:0]          r_byte, n_byte;
    fct_pkg::t_req       r_req, n_req;
    fct_pkg::t_rsp       r_rsp, n_rsp;
    logic                r_ov, n_ov;
    fct_pkg::t_rsp       r_out, n_out;

    logic [1:0]   rd_st;
    logic [127:0] rd_dat;
    logic         st_we;
    logic [1:0]   st_wd;
    logic         dat_we;
    logic [95:0]  key_bytes;
    logic [31:0]  key_pp;
    logic [AW-1:0] slot_nx;
    logic         key_hit;
    logic [31:0]  idle_t;
    logic [CW-1:0] cnt_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    assign key_pp    = {r_req.source_port, r_req.dest_port};
    assign key_bytes = {r_req.dest_port, r_req.dest_address, r_req.source_port,
                        r_req.source_address};
    assign slot_nx   = (r_slot == LAST) ? '0 : r_slot + 1'b1;
    assign key_hit   = (rd_dat[31:0] == r_req.source_address) && (rd_dat[63:32] == key_pp)
                       && (rd_dat[95:64] == r_req.dest_address);
    assign idle_t    = r_sec - rd_dat[127:96];
    assign cnt_inc   = r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        rd_st  <= mem_st[n_slot];
        rd_dat <= mem_dat[n_slot];
        if (st_we) begin
            mem_st[r_slot] <= st_wd;
        end
        if (dat_we) begin
            mem_dat[r_slot] <= {r_sec, r_req.dest_address, key_pp, r_req.source_address};
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_sec   = r_sec;
        n_h     = r_h;
        n_byte  = r_byte;
        n_req   = r_req;
        n_rsp   = r_rsp;
        n_ov    = r_ov && !i_out_ready;
        n_out   = r_out;
        st_we   = 1'b0;
        st_wd   = fct_pkg::ENT_FREE;
        dat_we  = 1'b0;

        case (r_state)
            S_CLR: begin
                st_we = 1'b1;
                if (r_slot == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_slot = slot_nx;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    n_rsp = '0;
                    case (i_in_data.func)
                        fct_pkg::FUNC_LOOKUP, fct_pkg::FUNC_CREATE: begin
                            n_h     = fct_pkg::FNV_BASIS;
                            n_byte  = '0;
                            n_state = S_HASH;
                        end
                        fct_pkg::FUNC_REMOVE: begin
                            if (32'(i_in_data.target_slot) < 32'(TABLE_SIZE)) begin
                                n_slot  = AW'(i_in_data.target_slot);
                                n_state = S_RMV;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        fct_pkg::FUNC_TICK: begin
                            n_sec   = r_sec + 32'd1;
                            n_state = S_FIN;
                        end
                        fct_pkg::FUNC_REAP: begin
                            n_slot  = '0;
                            n_cnt   = '0;
                            n_state = S_REAP;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_h    = (r_h ^ {24'd0, key_bytes[8*r_byte +: 8]}) * fct_pkg::FNV_PRIME;
                n_byte = r_byte + 4'd1;
                if (r_byte == 4'd11) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // modulo a power of two: keep the low hash bits
                n_slot  = r_h[AW-1:0];
                n_pc    = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (r_req.func == fct_pkg::FUNC_LOOKUP) begin
                    if (rd_st == fct_pkg::ENT_FREE) begin
                        n_rsp.status = fct_pkg::RSP_MISS;
                        n_state      = S_FIN;
                    end else if (rd_st == fct_pkg::ENT_ACTIVE && key_hit) begin
                        n_rsp.result_slot = fct_pkg::SLOT_W'(r_slot);
                        n_state           = S_FIN;
                    end
                end else if (rd_st == fct_pkg::ENT_FREE || rd_st == fct_pkg::ENT_CLOSED) begin
                    st_we             = 1'b1;
                    st_wd             = fct_pkg::ENT_ACTIVE;
                    dat_we            = 1'b1;
                    n_rsp.result_slot = fct_pkg::SLOT_W'(r_slot);
                    n_state           = S_FIN;
                end
                if (n_state == S_PROBE) begin
                    if (r_pc == TS - 1'b1) begin
                        n_rsp.status = (r_req.func == fct_pkg::FUNC_LOOKUP) ?
                                       fct_pkg::RSP_MISS : fct_pkg::RSP_FULL;
                        n_state      = S_FIN;
                    end else begin
                        n_pc   = r_pc + 1'b1;
                        n_slot = slot_nx;
                    end
                end
            end
            S_RMV: begin
                if (rd_st == fct_pkg::ENT_ACTIVE) begin
                    st_we = 1'b1;
                    st_wd = fct_pkg::ENT_CLOSED;
                end
                n_rsp.result_slot = r_req.target_slot;
                n_state           = S_FIN;
            end
            S_REAP: begin
                if (rd_st == fct_pkg::ENT_ACTIVE && idle_t > {16'd0, r_timeout}) begin
                    st_we = 1'b1;
                    st_wd = fct_pkg::ENT_CLOSED;
                    n_cnt = cnt_inc;
                end
                if (r_slot == LAST) begin
                    n_rsp.reaped_count = fct_pkg::COUNT_W'(n_cnt);
                    n_state            = S_FIN;
                end else begin
                    n_slot = slot_nx;
                end
            end
            S_FIN: begin
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_rsp;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_slot    <= '0;
            r_ov      <= 1'b0;
            r_sec     <= '0;
            r_timeout <= fct_pkg::TIMEOUT_RST;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_ov    <= n_ov;
            r_sec   <= n_sec;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
        end
        r_pc   <= n_pc;
        r_cnt  <= n_cnt;
        r_h    <= n_h;
        r_byte <= n_byte;
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_out  <= n_out;
    end

endmodule
